>>> rtl/hep_pkg.sv
// ---------------------------------------------------------------------------
// hep_pkg - shared types and constants of the Huffman encoder bit packer
// Item, result and command structs, operation and byte kind codes.
// ---------------------------------------------------------------------------
package hep_pkg;

	localparam int BYTE_BITS        = 8;
	localparam int CODE_BITS        = 16;
	localparam int LEN_BITS         = 5;
	localparam int PEND_BITS        = 24;
	localparam int MAX_CODE_LEN     = 16;
	localparam int CODE_CAP         = (MAX_CODE_LEN < CODE_BITS) ? MAX_CODE_LEN : CODE_BITS;
	localparam int SYMBOL_COUNT_DEF = 256;
	localparam int CMD_DEPTH        = 2;
	localparam int OUT_DEPTH        = 2;

	typedef enum logic [1:0] {
		MODE_LOAD,
		MODE_ENCODE,
		MODE_FLUSH
	} mode_t;

	typedef enum logic [1:0] {
		KIND_DATA,
		KIND_PARTIAL,
		KIND_COUNT
	} kind_t;

	typedef struct packed {
		logic [1:0]           mode;
		logic [7:0]           symbol;
		logic [CODE_BITS-1:0] code_word;
		logic [LEN_BITS-1:0]  code_length;
	} item_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] out_byte;
		logic [1:0]           byte_kind;
		logic                 last;
	} result_t;

	// command handed from the lookup side to the packer
	typedef struct packed {
		logic                 flush;
		logic [LEN_BITS-1:0]  len;
		logic [CODE_BITS-1:0] bits;
	} cmd_t;

endpackage

>>> rtl/hep_fifo.sv
// ---------------------------------------------------------------------------
// hep_fifo - small register queue
// Power-of-two depth, full/empty decoded from the count register, no pass-through when full.
// ---------------------------------------------------------------------------
module hep_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  T     wdata,
	output logic full,
	input  logic rd,
	output T     rdata,
	output logic empty
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	T                 mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr)
				wptr_q <= wptr_q + PTR_W'(1);
			if (do_rd)
				rptr_q <= rptr_q + PTR_W'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wdata;
	end

endmodule

>>> rtl/hep_front.sv
// ---------------------------------------------------------------------------
// hep_front - item intake and code table
// Loads table entries, looks up codes and issues packer commands.
// ---------------------------------------------------------------------------
module hep_front import hep_pkg::*; #(
	parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t item,
	output logic  full,
	output logic  cmd_wr,
	output cmd_t  cmd,
	input  logic  cmd_full
);
	localparam int IDX_W   = $clog2(SYMBOL_COUNT);
	localparam int ENTRY_W = LEN_BITS + CODE_BITS;

	logic [ENTRY_W-1:0]   table_q [SYMBOL_COUNT];
	logic [ENTRY_W-1:0]   rd_q;
	logic                 valid_s1;
	logic                 flush_s1;
	logic                 inrange_s1;
	logic                 accept;
	logic                 inrange;
	logic [IDX_W-1:0]     idx;
	logic [LEN_BITS-1:0]  cap_len;
	logic [CODE_BITS-1:0] cap_bits;
	logic                 is_load;
	logic                 is_cmd;

	assign full    = valid_s1 && cmd_full;
	assign accept  = push && !full;
	assign cmd_wr  = valid_s1 && !cmd_full;
	assign idx     = item.symbol[IDX_W-1:0];
	assign inrange = {1'b0, item.symbol} < 9'(SYMBOL_COUNT);
	assign is_load = (item.mode == MODE_LOAD);
	assign is_cmd  = (item.mode == MODE_ENCODE) || (item.mode == MODE_FLUSH);

	always_comb begin
		cap_len  = (item.code_length > LEN_BITS'(CODE_CAP)) ? LEN_BITS'(CODE_CAP)
		                                                   : item.code_length;
		cap_bits = item.code_word &
		           CODE_BITS'((17'(1) << cap_len) - 17'd1);
	end

	always_ff @(posedge clk) begin
		if (accept && is_load && inrange)
			table_q[idx] <= {cap_len, cap_bits};
		if (accept)
			rd_q <= table_q[idx];
		if (accept) begin
			flush_s1   <= (item.mode == MODE_FLUSH);
			inrange_s1 <= inrange;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= is_cmd;
		else if (cmd_wr)
			valid_s1 <= 1'b0;
	end

	always_comb begin
		cmd.flush = flush_s1;
		cmd.len   = inrange_s1 ? rd_q[ENTRY_W-1 -: LEN_BITS] : '0;
		cmd.bits  = inrange_s1 ? rd_q[CODE_BITS-1:0] : '0;
	end

endmodule

>>> rtl/hep_back.sv
// ---------------------------------------------------------------------------
// hep_back - bit packer
// Appends codes to the pending register and emits bytes, one per cycle while the result queue has room.
// ---------------------------------------------------------------------------
module hep_back import hep_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_empty,
	input  cmd_t    cmd,
	output logic    cmd_rd,
	output logic    res_wr,
	output result_t res,
	input  logic    res_full
);
	logic [PEND_BITS-1:0] bits_q;
	logic [LEN_BITS-1:0]  cnt_q;
	logic                 cnt_pend_q;

	logic [PEND_BITS-1:0] bits_d;
	logic [LEN_BITS-1:0]  cnt_d;
	logic                 cnt_pend_d;
	logic [PEND_BITS-1:0] src_bits;
	logic [LEN_BITS-1:0]  src_cnt;
	logic [LEN_BITS-1:0]  sh;
	logic [PEND_BITS-1:0] rem_bits;
	logic                 room;

	assign room = !res_full;

	always_comb begin
		// appended value when taking a new code, else the held state
		if (cnt_q > LEN_BITS'(BYTE_BITS)) begin
			src_bits = bits_q;
			src_cnt  = cnt_q;
		end else begin
			src_bits = PEND_BITS'(bits_q << cmd.len) | PEND_BITS'(cmd.bits);
			src_cnt  = cnt_q + cmd.len;
		end
		sh       = src_cnt - LEN_BITS'(BYTE_BITS);
		rem_bits = src_bits & PEND_BITS'((25'(1) << sh) - 25'd1);
	end

	always_comb begin
		bits_d     = bits_q;
		cnt_d      = cnt_q;
		cnt_pend_d = cnt_pend_q;
		cmd_rd     = 1'b0;
		res_wr     = 1'b0;
		res        = '0;
		if (cnt_pend_q) begin
			if (room) begin
				res_wr        = 1'b1;
				res.out_byte  = BYTE_BITS'(cnt_q);
				res.byte_kind = KIND_COUNT;
				res.last      = 1'b1;
				bits_d        = '0;
				cnt_d         = '0;
				cnt_pend_d    = 1'b0;
			end
		end else if (cnt_q > LEN_BITS'(BYTE_BITS)) begin
			if (room) begin
				res_wr        = 1'b1;
				res.out_byte  = BYTE_BITS'(src_bits >> sh);
				res.byte_kind = KIND_DATA;
				res.last      = (sh <= LEN_BITS'(BYTE_BITS));
				bits_d        = rem_bits;
				cnt_d         = sh;
			end
		end else if (!cmd_empty && room) begin
			cmd_rd = 1'b1;
			if (cmd.flush) begin
				res_wr = 1'b1;
				if (cnt_q != '0) begin
					res.out_byte  = bits_q[BYTE_BITS-1:0];
					res.byte_kind = KIND_PARTIAL;
					res.last      = 1'b0;
					cnt_pend_d    = 1'b1;
				end else begin
					res.out_byte  = '0;
					res.byte_kind = KIND_COUNT;
					res.last      = 1'b1;
					bits_d        = '0;
				end
			end else if (src_cnt > LEN_BITS'(BYTE_BITS)) begin
				res_wr        = 1'b1;
				res.out_byte  = BYTE_BITS'(src_bits >> sh);
				res.byte_kind = KIND_DATA;
				res.last      = (sh <= LEN_BITS'(BYTE_BITS));
				bits_d        = rem_bits;
				cnt_d         = sh;
			end else begin
				bits_d = src_bits;
				cnt_d  = src_cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q     <= '0;
			cnt_q      <= '0;
			cnt_pend_q <= 1'b0;
		end else begin
			bits_q     <= bits_d;
			cnt_q      <= cnt_d;
			cnt_pend_q <= cnt_pend_d;
		end
	end

endmodule

>>> rtl/huffman_encoder_bit_packer.sv
// ---------------------------------------------------------------------------
// huffman_encoder_bit_packer - Huffman encoder with MSB-first byte packer
// Code table lookup in front, bit packer behind, queues in between.
// ---------------------------------------------------------------------------
// Usage:
//   Input queue: drive item and push; the transaction completes on a clock
//   edge with push high and full low. Load items write a table entry, encode
//   items append the symbol's code, flush items close the stream.
//   Result queue: while empty is low the oldest byte sits on result; pop
//   high on a clock edge takes it.
//   With idle queues an item passes the lookup register, the command queue
//   and the result queue before its first result shows. Throughput: one item
//   per cycle into the lookup while full is low; loads end there. The packer
//   takes no new encode or flush while a second data byte or the count byte
//   of a flush is still to go out.
//   Its single emit path gives one byte per cycle while the result queue has room.
//   A stalled receiver fills the two-entry result queue, then the two-entry
//   command queue, then raises full; nothing is dropped.
//   Reset empties both queues and the pending bit register. The code table
//   is not cleared: encode only symbols that were loaded.
// ---------------------------------------------------------------------------
module huffman_encoder_bit_packer import hep_pkg::*; #(
	parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   item,
	output logic    full,
	input  logic    pop,
	output result_t result,
	output logic    empty
);
	logic    cmd_wr;
	cmd_t    cmd_in;
	logic    cmd_full;
	logic    cmd_rd;
	cmd_t    cmd_out;
	logic    cmd_empty;
	logic    res_wr;
	result_t res_in;
	logic    res_full;

	hep_front #(
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_wr   (cmd_wr),
		.cmd      (cmd_in),
		.cmd_full (cmd_full)
	);

	hep_fifo #(
		.T     (cmd_t),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (cmd_wr),
		.wdata (cmd_in),
		.full  (cmd_full),
		.rd    (cmd_rd),
		.rdata (cmd_out),
		.empty (cmd_empty)
	);

	hep_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd      (cmd_out),
		.cmd_rd   (cmd_rd),
		.res_wr   (res_wr),
		.res      (res_in),
		.res_full (res_full)
	);

	hep_fifo #(
		.T     (result_t),
		.DEPTH (OUT_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_wr),
		.wdata (res_in),
		.full  (res_full),
		.rd    (pop),
		.rdata (result),
		.empty (empty)
	);

endmodule

>>> tb/sv/huffman_encoder_bit_packer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// huffman_encoder_bit_packer_tb - self-checking bench for the bit packer
// A directed vector list (typed expectations where obvious) followed by
// random load/encode/flush streams, scored against a local packer model
// under several push/pop idle mixes and one long receiver hold-off.
// ---------------------------------------------------------------------------
module huffman_encoder_bit_packer_tb;
	import hep_pkg::*;

	localparam logic [1:0] MODE_IDLE    = 2'b11;   // unused mode, ignored by the block
	localparam int         NUM_SYMBOLS  = SYMBOL_COUNT_DEF;
	localparam int         ITEM_TARGET  = 1600;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         QUIET_LIMIT  = 3000;
	localparam int         DRAIN_CYCLES = 10;
	localparam int         MAX_REPORTS  = 10;

	typedef struct {
		item_t   it;
		int      n_typed;   // -1: expectation comes from the packer model
		result_t r0;
		result_t r1;
	} vector_t;

	logic    clk      = 1'b0;
	logic    arst_n   = 1'b0;
	logic    push     = 1'b0;
	item_t   item     = '0;
	logic    full;
	logic    pop      = 1'b0;
	result_t result;
	logic    empty;

	logic    hold_off = 1'b0;
	int      idle_pct = 0;
	int      stall_pct = 0;

	// packer model state
	logic [CODE_BITS-1:0] tbl_bits  [NUM_SYMBOLS];
	logic [LEN_BITS-1:0]  tbl_len   [NUM_SYMBOLS];
	bit                   tbl_valid [NUM_SYMBOLS];
	logic [7:0]           loaded_syms[$];
	int unsigned          acc_bits = 0;
	int unsigned          acc_cnt  = 0;

	result_t byte_stream_q[$];
	vector_t vectors[$];

	int items_sent = 0;
	int n_loads = 0;
	int n_encodes = 0;
	int n_flushes = 0;
	int bytes_checked = 0;
	int errors = 0;

	huffman_encoder_bit_packer dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.full(full),
		.pop(pop),
		.result(result),
		.empty(empty)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic result_t mk_res(logic [7:0] b, logic [1:0] k, logic l);
		result_t r;
		r.out_byte  = b;
		r.byte_kind = k;
		r.last      = l;
		return r;
	endfunction

	function automatic void add_row(logic [1:0] m, logic [7:0] s, logic [15:0] w,
			logic [4:0] l, int n = -1, result_t r0 = '0, result_t r1 = '0);
		vector_t v;
		v.it.mode        = m;
		v.it.symbol      = s;
		v.it.code_word   = w;
		v.it.code_length = l;
		v.n_typed        = n;
		v.r0             = r0;
		v.r1             = r1;
		vectors.push_back(v);
	endfunction

	// Returns the number of bytes one accepted item produces, gives them in r0/r1 and advances the model.
	function automatic int pack_item(input item_t it, output result_t r0, output result_t r1);
		int unsigned len;
		int unsigned sh;
		int          n;
		result_t     rs[2];
		n = 0;
		rs[0] = '0;
		rs[1] = '0;
		case (it.mode)
			MODE_LOAD: begin
				if (it.symbol < NUM_SYMBOLS) begin
					len = it.code_length;
					if (len > CODE_CAP)
						len = CODE_CAP;
					tbl_bits[it.symbol] = it.code_word & 16'((1 << len) - 1);
					tbl_len[it.symbol]  = 5'(len);
					if (!tbl_valid[it.symbol]) begin
						tbl_valid[it.symbol] = 1'b1;
						loaded_syms.push_back(it.symbol);
					end
				end
			end
			MODE_ENCODE: begin
				len = 0;
				sh  = 0;
				if (it.symbol < NUM_SYMBOLS) begin
					len = tbl_len[it.symbol];
					sh  = tbl_bits[it.symbol];
				end
				acc_bits = ((acc_bits << len) | sh) & ((1 << PEND_BITS) - 1);
				acc_cnt  = acc_cnt + len;
				// hold back the final 0..8 bits until flush
				while (acc_cnt > BYTE_BITS) begin
					sh = acc_cnt - BYTE_BITS;
					rs[n] = mk_res(8'(acc_bits >> sh), KIND_DATA, 1'b0);
					n = n + 1;
					acc_cnt  = sh;
					acc_bits = acc_bits & ((1 << sh) - 1);
				end
			end
			MODE_FLUSH: begin
				if (acc_cnt > 0) begin
					rs[n] = mk_res(8'(acc_bits), KIND_PARTIAL, 1'b0);
					n = n + 1;
				end
				rs[n] = mk_res(8'(acc_cnt), KIND_COUNT, 1'b0);
				n = n + 1;
				acc_bits = 0;
				acc_cnt  = 0;
			end
			default: ;
		endcase
		if (n > 0)
			rs[n-1].last = 1'b1;
		r0 = rs[0];
		r1 = rs[1];
		return n;
	endfunction

	function automatic void expect_results(int n, result_t r0, result_t r1);
		if (n > 0)
			byte_stream_q.push_back(r0);
		if (n > 1)
			byte_stream_q.push_back(r1);
	endfunction

	function automatic item_t random_item();
		item_t       it;
		int unsigned pick;
		it.symbol      = 8'($urandom);
		it.code_word   = 16'($urandom);
		it.code_length = 5'($urandom);
		pick = $urandom_range(99);
		if (pick < 6) begin
			it.mode = MODE_FLUSH;
		end else if (pick < 8) begin
			it.mode = MODE_IDLE;
		end else if (pick < 18 || loaded_syms.size() == 0) begin
			it.mode = MODE_LOAD;
			pick = $urandom_range(9);
			if (pick == 0)
				it.code_length = '0;
			else if (pick == 1)
				it.code_length = 5'($urandom_range(31, 17));
			else if (pick == 2)
				it.code_length = 5'd16;
			else
				it.code_length = 5'($urandom_range(16, 1));
		end else begin
			// only symbols with a loaded entry are encoded
			it.mode   = MODE_ENCODE;
			it.symbol = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
		end
		return it;
	endfunction

	task automatic offer(input item_t it);
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		case (it.mode)
			MODE_LOAD:   n_loads++;
			MODE_ENCODE: n_encodes++;
			MODE_FLUSH:  n_flushes++;
			default: ;
		endcase
		if (it.mode != MODE_IDLE)
			items_sent++;
	endtask

	task automatic check_byte(input result_t got);
		result_t want;
		if (byte_stream_q.size() == 0) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("ERROR: unexpected result byte %h kind %0d last %0d",
					got.out_byte, got.byte_kind, got.last);
		end else begin
			want = byte_stream_q.pop_front();
			if (got.out_byte !== want.out_byte || got.byte_kind !== want.byte_kind ||
					got.last !== want.last) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("ERROR: byte %0d exp %h/%0d/%0d got %h/%0d/%0d (byte/kind/last)",
						bytes_checked, want.out_byte, want.byte_kind, want.last,
						got.out_byte, got.byte_kind, got.last);
			end
			bytes_checked++;
		end
	endtask

	// receiver
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				check_byte(result);
			pop <= !hold_off && ($urandom_range(99) >= stall_pct);
		end
	end

	// long receiver hold-off while the sender keeps pushing
	initial begin
		wait (items_sent >= 80);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// watchdog: cycles with no transaction on either side
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
		end
		$display("ERROR: no transaction for %0d cycles", QUIET_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		item_t   it;
		result_t r0;
		result_t r1;
		int      n;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty flush straight out of reset, then the unused mode
		add_row(MODE_FLUSH,  8'h00, 16'h0000, 5'd0,  1, mk_res(8'h00, KIND_COUNT, 1'b1));
		add_row(MODE_IDLE,   8'hFF, 16'hFFFF, 5'h1F, 0);
		add_row(MODE_LOAD,   8'h00, 16'hFFFF, 5'd16, 0);
		add_row(MODE_LOAD,   8'hFF, 16'h0001, 5'd1,  0);
		add_row(MODE_LOAD,   8'h01, 16'hFFFF, 5'd31, 0);   // long code saturates
		add_row(MODE_LOAD,   8'h02, 16'hFFFF, 5'd0,  0);   // empty code
		add_row(MODE_LOAD,   8'h03, 16'hABCD, 5'd4,  0);   // upper code bits dropped
		add_row(MODE_LOAD,   8'h80, 16'h0000, 5'd16, 0);
		add_row(MODE_ENCODE, 8'hFF, 16'h0000, 5'd0,  0);
		// a single final bit must survive the flush
		add_row(MODE_FLUSH,  8'h00, 16'h0000, 5'd0,  2,
			mk_res(8'h01, KIND_PARTIAL, 1'b0), mk_res(8'h01, KIND_COUNT, 1'b1));
		add_row(MODE_ENCODE, 8'h00, 16'hFFFF, 5'h1F, 1, mk_res(8'hFF, KIND_DATA, 1'b1));
		// full last byte reports a count of eight
		add_row(MODE_FLUSH,  8'hFF, 16'hFFFF, 5'h1F, 2,
			mk_res(8'hFF, KIND_PARTIAL, 1'b0), mk_res(8'h08, KIND_COUNT, 1'b1));
		add_row(MODE_ENCODE, 8'h02, 16'h0000, 5'd0,  0);
		add_row(MODE_FLUSH,  8'h00, 16'h0000, 5'd0,  1, mk_res(8'h00, KIND_COUNT, 1'b1));
		add_row(MODE_ENCODE, 8'hFF, 16'h0000, 5'd0);
		add_row(MODE_ENCODE, 8'h01, 16'h0000, 5'd0);
		add_row(MODE_ENCODE, 8'h03, 16'h0000, 5'd0);
		add_row(MODE_ENCODE, 8'h80, 16'h0000, 5'd0);
		add_row(MODE_ENCODE, 8'h00, 16'h0000, 5'd0);
		add_row(MODE_FLUSH,  8'h00, 16'h0000, 5'd0);
		add_row(MODE_LOAD,   8'h03, 16'h1234, 5'd17);
		add_row(MODE_ENCODE, 8'h03, 16'h0000, 5'd0);
		add_row(MODE_ENCODE, 8'h02, 16'h0000, 5'd0);
		add_row(MODE_FLUSH,  8'h00, 16'h0000, 5'd0);

		foreach (vectors[i]) begin
			offer(vectors[i].it);
			n = pack_item(vectors[i].it, r0, r1);
			if (vectors[i].n_typed >= 0)
				expect_results(vectors[i].n_typed, vectors[i].r0, vectors[i].r1);
			else
				expect_results(n, r0, r1);
		end

		while (items_sent < ITEM_TARGET) begin
			case (items_sent * 4 / ITEM_TARGET)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 88;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 88;
				end
				default: begin
					idle_pct  = 27;
					stall_pct = 27;
				end
			endcase
			it = random_item();
			offer(it);
			n = pack_item(it, r0, r1);
			expect_results(n, r0, r1);
		end
		push <= 1'b0;

		while (byte_stream_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items (%0d loads, %0d encodes, %0d flushes), checked %0d bytes",
			items_sent, n_loads, n_encodes, n_flushes, bytes_checked);
		$display("Idle mixes: none, push 88%%, pop 88%%, both 27%%, %0d-cycle hold-off; %0d mismatches",
			HOLD_CYCLES, errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
